// File: hdl/urs_pkg.sv
// ----------------------------------------------------------------------------
// urs_pkg: shared types and constants for the ultrasonic ranging sequencer
// Field widths, register defaults, register indexes and the constants of the
// distance conversion.
// ----------------------------------------------------------------------------
package urs_pkg;

   // Default tick counter width.
   localparam int COUNT_BITS_DEF = 20;

   // Field widths.
   localparam int PERIOD_BITS  = 20;
   localparam int TRIGGER_BITS = 10;
   localparam int WINDOW_BITS  = 20;
   localparam int SLOPE_BITS   = 12;
   localparam int OFFSET_BITS  = 20;
   localparam int PULSE_BITS   = 20;
   localparam int DIST_BITS    = 17;

   // Register defaults.
   localparam logic [PERIOD_BITS-1:0]  PERIOD_RESET  = 20'd250000;
   localparam logic [TRIGGER_BITS-1:0] TRIGGER_RESET = 10'd10;
   localparam logic [WINDOW_BITS-1:0]  WINDOW_RESET  = 20'd50000;
   localparam logic [SLOPE_BITS-1:0]   SLOPE_RESET   = 12'd2024;
   localparam logic [OFFSET_BITS-1:0]  OFFSET_RESET  = 20'd326130;

   // Configuration port.
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [2:0] {
      REG_PERIOD  = 3'd0,
      REG_TRIGGER = 3'd1,
      REG_WINDOW  = 3'd2,
      REG_SLOPE   = 3'd3,
      REG_OFFSET  = 3'd4
   } reg_index_type;

   // Distance conversion: divide by 100000 as a shift by 5 followed by a
   // reciprocal multiply for the remaining factor of 3125.
   localparam int DIST_DIVISOR     = 100000;
   localparam int DIST_MAX         = 65535;
   localparam int DIST_SHIFT       = 5;
   localparam int DIST_RESIDUAL    = DIST_DIVISOR / (2 ** DIST_SHIFT);
   localparam int DIST_X_BITS      = 28;
   localparam int DIST_RECIP_SHIFT = 40;
   localparam int DIST_RECIP_BITS  = 29;
   localparam logic [DIST_RECIP_BITS-1:0] DIST_RECIP = DIST_RECIP_BITS'(
      ((64'd1 << DIST_RECIP_SHIFT) + 64'(DIST_RESIDUAL) - 64'd1) / 64'(DIST_RESIDUAL));
   localparam logic [63:0] DIST_SAT_LIMIT = 64'(DIST_MAX + 1) * 64'(DIST_DIVISOR);

   // Configuration register set.
   typedef struct packed {
      logic [PERIOD_BITS-1:0]  period_ticks;
      logic [TRIGGER_BITS-1:0] trigger_ticks;
      logic [WINDOW_BITS-1:0]  window_ticks;
      logic [SLOPE_BITS-1:0]   slope;
      logic [OFFSET_BITS-1:0]  offset;
   } cfg_type;

   // Per-tick results that ride along the conversion pipeline.
   typedef struct packed {
      logic                  trigger_level;
      logic                  measure_valid;
      logic [PULSE_BITS-1:0] pulse_ticks;
   } flag_type;

endpackage

// File: hdl/urs_if.sv
// ----------------------------------------------------------------------------
// urs_if: channel interfaces of the ultrasonic ranging sequencer
// A tick channel carrying the sampled echo and a result channel carrying the
// trigger drive and the measurement of each tick.
// ----------------------------------------------------------------------------
interface urs_req_if;
   logic valid;
   logic ready;
   logic echo_level;

   modport source (output valid, output echo_level, input ready);
   modport sink   (input valid, input echo_level, output ready);
endinterface

interface urs_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  trigger_level;
   logic                                  measure_valid;
   logic [urs_pkg::PULSE_BITS-1:0]        pulse_ticks;
   logic signed [urs_pkg::DIST_BITS-1:0]  distance_value;

   modport source (output valid, output trigger_level, output measure_valid,
                   output pulse_ticks, output distance_value, input ready);
   modport sink   (input valid, input trigger_level, input measure_valid,
                   input pulse_ticks, input distance_value, output ready);
endinterface

// File: hdl/urs_csr.sv
// ----------------------------------------------------------------------------
// urs_csr: configuration registers
// APB-style register file holding period, trigger, window and conversion
// settings. Writes complete in the access cycle; reads are combinational.
// ----------------------------------------------------------------------------
module urs_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [urs_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [urs_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [urs_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready,
   output urs_pkg::cfg_type                    cfg
);

   urs_pkg::cfg_type       cfg_ff;
   urs_pkg::reg_index_type reg_index;
   logic                   write_en;

   assign reg_index = urs_pkg::reg_index_type'(paddr[urs_pkg::CSR_ADDR_BITS-1:2]);
   assign write_en  = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   // Register writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_ticks  <= urs_pkg::PERIOD_RESET;
         cfg_ff.trigger_ticks <= urs_pkg::TRIGGER_RESET;
         cfg_ff.window_ticks  <= urs_pkg::WINDOW_RESET;
         cfg_ff.slope         <= urs_pkg::SLOPE_RESET;
         cfg_ff.offset        <= urs_pkg::OFFSET_RESET;
      end else if (write_en) begin
         case (reg_index)
            urs_pkg::REG_PERIOD: begin
               cfg_ff.period_ticks <= pwdata[urs_pkg::PERIOD_BITS-1:0];
            end
            urs_pkg::REG_TRIGGER: begin
               cfg_ff.trigger_ticks <= pwdata[urs_pkg::TRIGGER_BITS-1:0];
            end
            urs_pkg::REG_WINDOW: begin
               cfg_ff.window_ticks <= pwdata[urs_pkg::WINDOW_BITS-1:0];
            end
            urs_pkg::REG_SLOPE: begin
               cfg_ff.slope <= pwdata[urs_pkg::SLOPE_BITS-1:0];
            end
            urs_pkg::REG_OFFSET: begin
               cfg_ff.offset <= pwdata[urs_pkg::OFFSET_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Read mux.
   always_comb begin
      case (reg_index)
         urs_pkg::REG_PERIOD:  prdata = urs_pkg::CSR_DATA_BITS'(cfg_ff.period_ticks);
         urs_pkg::REG_TRIGGER: prdata = urs_pkg::CSR_DATA_BITS'(cfg_ff.trigger_ticks);
         urs_pkg::REG_WINDOW:  prdata = urs_pkg::CSR_DATA_BITS'(cfg_ff.window_ticks);
         urs_pkg::REG_SLOPE:   prdata = urs_pkg::CSR_DATA_BITS'(cfg_ff.slope);
         urs_pkg::REG_OFFSET:  prdata = urs_pkg::CSR_DATA_BITS'(cfg_ff.offset);
         default:              prdata = '0;
      endcase
   end

endmodule

// File: hdl/urs_timing.sv
// ----------------------------------------------------------------------------
// urs_timing: tick counter, trigger and echo edge tracking
// Updates the per-tick state on each accepted word and registers the trigger
// level, edge result and tick value into the first pipeline stage.
// ----------------------------------------------------------------------------
module urs_timing #(
   parameter int COUNT_BITS = urs_pkg::COUNT_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  urs_pkg::cfg_type        cfg,
   urs_req_if.sink                 req_chan,
   input  logic                    s1_ready,
   output logic                    s1_valid,
   output urs_pkg::flag_type       s1_word,
   output logic [COUNT_BITS-1:0]   s1_tick
);

   localparam int CMP_BITS = (COUNT_BITS > urs_pkg::PERIOD_BITS) ?
                             COUNT_BITS : urs_pkg::PERIOD_BITS;

   logic [COUNT_BITS-1:0]           tick_ff, tick_in, tick_now;
   logic [COUNT_BITS-1:0]           rise_ff, rise_in;
   logic                            prev_ff, prev_in;
   logic                            trig_ff, trig_in;
   logic                            s1_valid_ff;
   urs_pkg::flag_type               s1_word_ff;
   logic [COUNT_BITS-1:0]           s1_tick_ff;
   logic [CMP_BITS-1:0]             now_ext;
   logic                            in_window, rise_edge, fall_edge;
   logic                            stage_ready, accept;
   logic [COUNT_BITS-1:0]           width_now;
   logic [urs_pkg::PULSE_BITS-1:0]  pulse_now;

   assign stage_ready    = !s1_valid_ff || s1_ready;
   assign req_chan.ready = stage_ready;
   assign accept         = req_chan.valid && stage_ready;
   assign s1_valid       = s1_valid_ff;
   assign s1_word        = s1_word_ff;
   assign s1_tick        = s1_tick_ff;

   // Wrap the counter, then evaluate trigger and echo edges inside the window.
   always_comb begin
      tick_now  = (CMP_BITS'(tick_ff) >= CMP_BITS'(cfg.period_ticks)) ? '0 : tick_ff;
      now_ext   = CMP_BITS'(tick_now);
      in_window = now_ext < CMP_BITS'(cfg.window_ticks);
      trig_in   = trig_ff;
      if (in_window && (now_ext == '0)) begin
         trig_in = 1'b1;
      end
      if (in_window && (now_ext == CMP_BITS'(cfg.trigger_ticks))) begin
         trig_in = 1'b0;
      end
      rise_edge = in_window && !prev_ff && req_chan.echo_level;
      fall_edge = in_window && prev_ff && !req_chan.echo_level;
      rise_in   = rise_edge ? tick_now : rise_ff;
      prev_in   = in_window ? req_chan.echo_level : prev_ff;
      tick_in   = tick_now + COUNT_BITS'(1);
      // Width wraps modulo the counter size before it is fitted to the field.
      width_now = tick_now - rise_ff;
      pulse_now = fall_edge ? urs_pkg::PULSE_BITS'(width_now) : '0;
   end

   // Per-tick state and the first pipeline stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff     <= '0;
         rise_ff     <= '0;
         prev_ff     <= 1'b0;
         trig_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            tick_ff <= tick_in;
            rise_ff <= rise_in;
            prev_ff <= prev_in;
            trig_ff <= trig_in;
         end
         if (stage_ready) begin
            s1_valid_ff              <= req_chan.valid;
            s1_word_ff.trigger_level <= trig_in;
            s1_word_ff.measure_valid <= fall_edge;
            s1_word_ff.pulse_ticks   <= pulse_now;
            s1_tick_ff               <= tick_now;
         end
      end
   end

endmodule

// File: hdl/urs_convert.sv
// ----------------------------------------------------------------------------
// urs_convert: distance conversion pipeline and result register
// Computes (slope*tick - offset)/100000 truncated toward zero and saturated,
// over four registered stages that stall independently.
// ----------------------------------------------------------------------------
module urs_convert #(
   parameter int COUNT_BITS = urs_pkg::COUNT_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  urs_pkg::cfg_type        cfg,
   input  logic                    s1_valid,
   input  urs_pkg::flag_type       s1_word,
   input  logic [COUNT_BITS-1:0]   s1_tick,
   output logic                    s1_ready,
   urs_rsp_if.source               rsp_chan
);

   localparam int PROD_BITS  = urs_pkg::SLOPE_BITS + COUNT_BITS;
   localparam int NUM_BITS   = PROD_BITS + 1;
   localparam int QPROD_BITS = urs_pkg::DIST_X_BITS + urs_pkg::DIST_RECIP_BITS;

   // Stage 2: product.
   logic                             v2_ff;
   urs_pkg::flag_type                w2_ff;
   logic [PROD_BITS-1:0]             prod_ff, prod_in;
   // Stage 3: sign, saturation and scaled magnitude.
   logic                             v3_ff, neg3_ff, sat3_ff;
   urs_pkg::flag_type                w3_ff;
   logic [urs_pkg::DIST_X_BITS-1:0]  x3_ff;
   // Stage 4: reciprocal product.
   logic                             v4_ff, neg4_ff, sat4_ff;
   urs_pkg::flag_type                w4_ff;
   logic [QPROD_BITS-1:0]            qprod_ff, qprod_in;
   // Stage 5: result register.
   logic                             out_valid_ff;
   urs_pkg::flag_type                out_word_ff;
   logic [urs_pkg::DIST_BITS-1:0]    dist_ff, dist_in;

   logic signed [NUM_BITS-1:0]       num;
   logic [NUM_BITS-1:0]              mag;
   logic [63:0]                      mag_wide;
   logic                             neg_now, sat_now;
   logic [urs_pkg::DIST_X_BITS-1:0]  x_now;
   logic [urs_pkg::DIST_BITS-1:0]    quot;
   logic                             r2, r3, r4, r5;

   // Each stage takes a new word when it is empty or its successor moves.
   assign r5       = !out_valid_ff || rsp_chan.ready;
   assign r4       = !v4_ff || r5;
   assign r3       = !v3_ff || r4;
   assign r2       = !v2_ff || r3;
   assign s1_ready = r2;

   // Datapath between the stages.
   always_comb begin
      prod_in  = PROD_BITS'(cfg.slope) * PROD_BITS'(s1_tick);
      num      = $signed({1'b0, prod_ff}) - $signed(NUM_BITS'(cfg.offset));
      neg_now  = num[NUM_BITS-1];
      mag      = neg_now ? -num : num;
      mag_wide = 64'(mag);
      sat_now  = !neg_now && (mag_wide >= urs_pkg::DIST_SAT_LIMIT);
      x_now    = mag_wide[urs_pkg::DIST_SHIFT +: urs_pkg::DIST_X_BITS];
      qprod_in = QPROD_BITS'(x3_ff) * QPROD_BITS'(urs_pkg::DIST_RECIP);
      quot     = qprod_ff[urs_pkg::DIST_RECIP_SHIFT +: urs_pkg::DIST_BITS];
      // The offset bounds the negative side well above the lower limit.
      if (!w4_ff.measure_valid) begin
         dist_in = '0;
      end else if (sat4_ff) begin
         dist_in = urs_pkg::DIST_BITS'(urs_pkg::DIST_MAX);
      end else if (neg4_ff) begin
         dist_in = -quot;
      end else begin
         dist_in = quot;
      end
   end

   // Pipeline registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (r2) begin
            v2_ff   <= s1_valid;
            w2_ff   <= s1_word;
            prod_ff <= prod_in;
         end
         if (r3) begin
            v3_ff   <= v2_ff;
            w3_ff   <= w2_ff;
            neg3_ff <= neg_now;
            sat3_ff <= sat_now;
            x3_ff   <= x_now;
         end
         if (r4) begin
            v4_ff    <= v3_ff;
            w4_ff    <= w3_ff;
            neg4_ff  <= neg3_ff;
            sat4_ff  <= sat3_ff;
            qprod_ff <= qprod_in;
         end
         if (r5) begin
            out_valid_ff <= v4_ff;
            out_word_ff  <= w4_ff;
            dist_ff      <= dist_in;
         end
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.trigger_level  = out_word_ff.trigger_level;
   assign rsp_chan.measure_valid  = out_word_ff.measure_valid;
   assign rsp_chan.pulse_ticks    = out_word_ff.pulse_ticks;
   assign rsp_chan.distance_value = $signed(dist_ff);

endmodule

// File: hdl/ultrasonic_ranging_sequencer.sv
// ----------------------------------------------------------------------------
// ultrasonic_ranging_sequencer: trigger and echo timing for a rangefinder
// Each tick word carries the echo level; each result word carries the trigger
// drive and, on a falling echo edge, the pulse width and converted distance.
//
//   Channel   Direction  Handshake            Word
//   req_chan  in         valid/ready          echo_level
//   rsp_chan  out        valid/ready          trigger_level, measure_valid,
//                                             pulse_ticks, distance_value
//   psel...   in/out     APB-style, pready=1  five configuration registers
//
// One tick word is accepted per clock cycle while no stage stalls; each tick
// passes through the five register stages before its result is valid.
// Synchronous reset clears the tick state and pipeline and restores register
// defaults; there is no clearing pass.
// Each stage stalls only when full and blocked, so bubbles collapse and new
// ticks keep entering behind a waiting result until all five stages are full.
// ----------------------------------------------------------------------------
module ultrasonic_ranging_sequencer #(
   parameter int COUNT_BITS = urs_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   urs_req_if.sink                             req_chan,
   urs_rsp_if.source                           rsp_chan,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [urs_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [urs_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [urs_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready
);

   urs_pkg::cfg_type        cfg;
   logic                    s1_valid, s1_ready;
   urs_pkg::flag_type       s1_word;
   logic [COUNT_BITS-1:0]   s1_tick;

   // Configuration registers.
   urs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Tick state and first stage.
   urs_timing #(.COUNT_BITS(COUNT_BITS)) u_timing (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .s1_ready (s1_ready),
      .s1_valid (s1_valid),
      .s1_word  (s1_word),
      .s1_tick  (s1_tick)
   );

   // Distance conversion and result register.
   urs_convert #(.COUNT_BITS(COUNT_BITS)) u_convert (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .s1_valid (s1_valid),
      .s1_word  (s1_word),
      .s1_tick  (s1_tick),
      .s1_ready (s1_ready),
      .rsp_chan (rsp_chan)
   );

`ifndef SYNTHESIS
   // A word without a measurement carries zero width and distance.
   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.measure_valid |->
         (rsp_chan.pulse_ticks == '0) && (rsp_chan.distance_value == '0))
      else $error("result without measurement carries nonzero fields");

   // An empty result register lets the whole pipeline advance.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_chan.valid |-> req_chan.ready)
      else $error("tick channel stalled with empty result register");

   // The distance never falls below the lower limit of -1024.
   a_distance_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.distance_value >= -17'sd1024))
      else $error("distance below lower limit");
`endif

endmodule

// File: verif/tb_ultrasonic_ranging_sequencer.sv
// ----------------------------------------------------------------------------
// tb_ultrasonic_ranging_sequencer: self-checking bench for the ranging sequencer
// Feeds echo tick words through the input channel and checks every result
// word against a cycle-free tick predictor. It programs the registers over the
// configuration port between phases, and varies sender gaps and receiver
// stalls, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_ultrasonic_ranging_sequencer;

   localparam int TICK_BITS   = urs_pkg::COUNT_BITS_DEF;
   localparam int DIST_FLOOR  = -1024;
   localparam int HOLD_CYCLES = 300;
   localparam int LIMIT       = 200000;
   localparam int PHASE_TICKS = 50;

   // One result word as the predictor sees it.
   typedef struct packed {
      logic                                 trigger_level;
      logic                                 measure_valid;
      logic [urs_pkg::PULSE_BITS-1:0]       pulse_ticks;
      logic signed [urs_pkg::DIST_BITS-1:0] distance_value;
   } tick_result_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              psel = 1'b0;
   logic                              penable = 1'b0;
   logic                              pwrite = 1'b0;
   logic [urs_pkg::CSR_ADDR_BITS-1:0] paddr = '0;
   logic [urs_pkg::CSR_DATA_BITS-1:0] pwdata = '0;
   logic [urs_pkg::CSR_DATA_BITS-1:0] prdata;
   logic                              pready;

   urs_req_if req_bus ();
   urs_rsp_if rsp_bus ();

   ultrasonic_ranging_sequencer uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Clock with a period of four units.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Echo levels waiting to be sent and the results they must produce.
   logic            echo_pending[$];
   tick_result_type results_due[$];
   int              ticks_queued = 0;
   int              ticks_accepted = 0;
   int              error_count = 0;
   int              measure_count = 0;
   int              settings_count = 0;
   int              send_gap_pct = 31;
   int              recv_stall_pct = 67;
   int              hold_seq = 0;
   int              hold_taken = 0;
   int              hold_left = 0;
   int              cycle_count = 0;

   // Predictor state and its copy of the registers.
   urs_pkg::cfg_type     regs;
   logic [TICK_BITS-1:0] tick_now;
   logic                 echo_was;
   logic [TICK_BITS-1:0] rise_at;
   logic                 trigger_on;

   // Advances the predictor by one tick and returns the result word it owes.
   function automatic tick_result_type next_tick_result(input logic echo);
      tick_result_type res;
      longint          product;
      longint          quotient;
      res = '0;
      if (tick_now >= TICK_BITS'(regs.period_ticks))
         tick_now = '0;
      if (tick_now < TICK_BITS'(regs.window_ticks)) begin
         if (tick_now == '0)
            trigger_on = 1'b1;
         if (tick_now == TICK_BITS'(regs.trigger_ticks))
            trigger_on = 1'b0;
         if (!echo_was && echo)
            rise_at = tick_now;
         if (echo_was && !echo) begin
            res.measure_valid = 1'b1;
            res.pulse_ticks = urs_pkg::PULSE_BITS'(TICK_BITS'(tick_now - rise_at));
            product = longint'(regs.slope) * longint'(tick_now) - longint'(regs.offset);
            // Signed division truncates toward zero.
            quotient = product / longint'(urs_pkg::DIST_DIVISOR);
            if (quotient < DIST_FLOOR)
               quotient = DIST_FLOOR;
            if (quotient > urs_pkg::DIST_MAX)
               quotient = urs_pkg::DIST_MAX;
            res.distance_value = quotient[urs_pkg::DIST_BITS-1:0];
         end
         echo_was = echo;
      end
      tick_now = tick_now + 1'b1;
      res.trigger_level = trigger_on;
      return res;
   endfunction

   // Driver: offers queued echo levels and predicts each accepted word.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            results_due.push_back(next_tick_result(req_bus.echo_level));
            ticks_accepted++;
         end
         if (req_bus.valid && !req_bus.ready) begin
            // The offered word stays on the bus until it is taken.
         end else if (echo_pending.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            req_bus.valid <= 1'b1;
            req_bus.echo_level <= echo_pending.pop_front();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Monitor: checks each result word and drives the receiver stalls.
   always @(posedge clock) begin : result_check
      tick_result_type due;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (rsp_bus.measure_valid)
               measure_count++;
            if (results_due.size() == 0) begin
               error_count++;
               $display("%0t: result word with none expected (trigger %0b valid %0b)",
                        $time, rsp_bus.trigger_level, rsp_bus.measure_valid);
            end else begin
               due = results_due.pop_front();
               if (rsp_bus.trigger_level !== due.trigger_level) begin
                  error_count++;
                  $display("%0t: trigger_level expected %0b actual %0b",
                           $time, due.trigger_level, rsp_bus.trigger_level);
               end
               if (rsp_bus.measure_valid !== due.measure_valid) begin
                  error_count++;
                  $display("%0t: measure_valid expected %0b actual %0b",
                           $time, due.measure_valid, rsp_bus.measure_valid);
               end
               if (rsp_bus.pulse_ticks !== due.pulse_ticks) begin
                  error_count++;
                  $display("%0t: pulse_ticks expected %0d actual %0d",
                           $time, due.pulse_ticks, rsp_bus.pulse_ticks);
               end
               if (rsp_bus.distance_value !== due.distance_value) begin
                  error_count++;
                  $display("%0t: distance_value expected %0d actual %0d",
                           $time, due.distance_value, rsp_bus.distance_value);
               end
            end
         end
         if (hold_taken != hold_seq) begin
            hold_taken <= hold_seq;
            hold_left <= HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Queues a run of identical echo levels.
   task automatic push_echo(input logic level, input int count);
      for (int i = 0; i < count; i++) begin
         echo_pending.push_back(level);
         ticks_queued++;
      end
   endtask

   // Queues well-formed echo pulses with random widths, plus some noise.
   task automatic push_pulses(input int count);
      int left;
      int run;
      left = count;
      while (left > 0) begin
         if ($urandom_range(9) == 0) begin
            push_echo(1'($urandom_range(1)), 1);
            left--;
         end else begin
            run = $urandom_range(1, 6);
            if (run > left)
               run = left;
            push_echo(1'b0, run);
            left -= run;
            run = $urandom_range(1, 8);
            if (run > left)
               run = left;
            push_echo(1'b1, run);
            left -= run;
         end
      end
   endtask

   // Writes one register through a setup and an access cycle.
   task automatic write_register(input urs_pkg::reg_index_type index,
                                 input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         urs_pkg::REG_PERIOD:  regs.period_ticks = value[urs_pkg::PERIOD_BITS-1:0];
         urs_pkg::REG_TRIGGER: regs.trigger_ticks = value[urs_pkg::TRIGGER_BITS-1:0];
         urs_pkg::REG_WINDOW:  regs.window_ticks = value[urs_pkg::WINDOW_BITS-1:0];
         urs_pkg::REG_SLOPE:   regs.slope = value[urs_pkg::SLOPE_BITS-1:0];
         urs_pkg::REG_OFFSET:  regs.offset = value[urs_pkg::OFFSET_BITS-1:0];
         default: ;
      endcase
   endtask

   // Waits until every queued word is taken and every result has come back.
   task automatic wait_drained();
      while (ticks_accepted != ticks_queued || results_due.size() != 0)
         @(posedge clock);
   endtask

   // Programs a full register set once the block is idle.
   task automatic apply_settings(input int period, input int trigger, input int window,
                                 input int slope_val, input int offset_val);
      wait_drained();
      write_register(urs_pkg::REG_PERIOD, period);
      write_register(urs_pkg::REG_TRIGGER, trigger);
      write_register(urs_pkg::REG_WINDOW, window);
      write_register(urs_pkg::REG_SLOPE, slope_val);
      write_register(urs_pkg::REG_OFFSET, offset_val);
      settings_count++;
   endtask

   // Timeout guard.
   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // Stimulus sequence.
   initial begin : stimulus
      int period;
      int window;
      req_bus.valid = 1'b0;
      req_bus.echo_level = 1'b0;
      rsp_bus.ready = 1'b0;
      regs.period_ticks = urs_pkg::PERIOD_RESET;
      regs.trigger_ticks = urs_pkg::TRIGGER_RESET;
      regs.window_ticks = urs_pkg::WINDOW_RESET;
      regs.slope = urs_pkg::SLOPE_RESET;
      regs.offset = urs_pkg::OFFSET_RESET;
      tick_now = '0;
      echo_was = 1'b0;
      rise_at = '0;
      trigger_on = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: one short pulse, a negative distance.
      push_echo(1'b0, 2);
      push_echo(1'b1, 3);
      push_echo(1'b0, 1);

      // Short period with a narrower window: echo outside the window is held,
      // and a pulse that spans the wrap gives a wrapped width.
      apply_settings(8, 3, 6, 4095, 0);
      push_echo(1'b1, 4);
      push_echo(1'b0, 2);
      push_echo(1'b1, 4);
      push_echo(1'b0, 2);

      // Period zero pins the counter, which also sits beyond the new period;
      // a zero trigger length keeps the trigger low.
      apply_settings(0, 0, 1048575, 0, 1048575);
      push_echo(1'b1, 1);
      push_echo(1'b0, 1);
      push_echo(1'b1, 1);
      push_echo(1'b0, 1);

      // Random phases under three idling schemes.
      for (int ph = 0; ph < 8; ph++) begin
         wait_drained();
         if (ph < 3) begin
            send_gap_pct = 31;
            recv_stall_pct = 67;
         end else if (ph < 6) begin
            send_gap_pct = 67;
            recv_stall_pct = 31;
         end else begin
            send_gap_pct = 0;
            recv_stall_pct = 0;
         end
         if (ph == 4) begin
            apply_settings(1048575, 1023, 1048575, 4095, 1048575);
         end else if (ph == 2) begin
            apply_settings(1, 1, 1, 0, 0);
         end else begin
            period = $urandom_range(1, 48);
            window = $urandom_range(1, 40);
            apply_settings(period, $urandom_range(0, 24), window,
                           $urandom_range(4095), $urandom_range(1048575));
         end
         push_pulses(PHASE_TICKS);
         // Long receiver hold-off while the sender keeps offering words.
         if (ph == 7)
            hold_seq++;
      end

      wait_drained();
      repeat (20) @(posedge clock);
      $display("Sent %0d tick words over %0d register settings; %0d measurements seen.",
               ticks_accepted, settings_count, measure_count);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
